[rtl/etc1_pkg.sv]
// ----------------------------------------------------------------------------
// ETC1 block decoder package
// Shared types, field positions and small decode functions.
// ----------------------------------------------------------------------------
package etc1_pkg;

    localparam int BlockBits  = 64;
    localparam int InBits     = 2 * BlockBits;
    localparam int PixBits    = 36;
    localparam int OutBits    = 40;
    localparam int PixCount   = 16;
    localparam int CntBits    = 4;
    localparam int QueueDepth = 2;

    localparam logic [CntBits-1:0] LastPix = CntBits'(PixCount - 1);

    typedef logic [7:0] chan_t;

    typedef struct packed {
        chan_t [2:0]  base0;
        chan_t [2:0]  base1;
        logic  [2:0]  tab0;
        logic  [2:0]  tab1;
        logic         flip;
        logic  [31:0] idx;
        logic  [63:0] alpha;
    } desc_t;

    typedef struct packed {
        logic [1:0] px;
        logic [1:0] py;
        chan_t      r;
        chan_t      g;
        chan_t      b;
        chan_t      a;
    } pixel_t;

    function automatic chan_t widen5(input logic [4:0] c);
        widen5 = {c, c[4:2]};
    endfunction

    function automatic chan_t widen4(input logic [3:0] c);
        widen4 = {c, c};
    endfunction

    function automatic logic [7:0] mod_mag(input logic [2:0] tab, input logic big);
        logic [7:0] m;
        m = 8'd0;
        unique case ({tab, big})
            4'b000_0: m = 8'd2;
            4'b000_1: m = 8'd8;
            4'b001_0: m = 8'd5;
            4'b001_1: m = 8'd17;
            4'b010_0: m = 8'd9;
            4'b010_1: m = 8'd29;
            4'b011_0: m = 8'd13;
            4'b011_1: m = 8'd42;
            4'b100_0: m = 8'd18;
            4'b100_1: m = 8'd60;
            4'b101_0: m = 8'd24;
            4'b101_1: m = 8'd80;
            4'b110_0: m = 8'd33;
            4'b110_1: m = 8'd106;
            4'b111_0: m = 8'd47;
            4'b111_1: m = 8'd183;
            default:  m = 8'd0;
        endcase
        mod_mag = m;
    endfunction

endpackage

[rtl/etc1_block_decoder.sv]
// ----------------------------------------------------------------------------
// ETC1 block decoder
// Decodes ETC1 / ETC1A4 4x4 blocks into sixteen RGBA8 pixels, row-major.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  s       | s_tvalid s_tready s_tdata[127:0] | color_word, alpha_word
//  m       | m_tvalid m_tready m_tdata[39:0]  | pixel_x..alpha, m_tlast=last
//  cfg     | cfg_valid cfg_ready cfg_data     | alpha_mode
//
//  The pixel engine emits one pixel per cycle while the output is not stalled.
//  Base colors decode on input; a two-block queue lets the input side run ahead.
//  A taken block is queued first; its first pixel is then registered for output.
//  Reset clears the queue, pixel counter, output valid and alpha_mode.
//  A stalled output holds the pixel engine; the input stalls when the queue fills.
// ----------------------------------------------------------------------------
module etc1_block_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [etc1_pkg::InBits-1:0]   s_tdata,   // color_word, alpha_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [etc1_pkg::OutBits-1:0]  m_tdata,   // pixel_x, pixel_y, red,
                                                     // green, blue, alpha, pad
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);
    import etc1_pkg::*;

    desc_t              f_desc;
    desc_t              q_desc;
    logic               q_valid;
    logic               q_pop;
    logic [PixBits-1:0] pixel;

    etc1_front u_front (
        .color_word (s_tdata[BlockBits-1:0]),
        .alpha_word (s_tdata[InBits-1:BlockBits]),
        .desc       (f_desc)
    );

    etc1_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_desc  (f_desc),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_desc  (q_desc)
    );

    etc1_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_desc    (q_desc),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_pixel   (pixel),
        .m_tlast   (m_tlast)
    );

    assign cfg_ready = 1'b1;

    // pixel_t packs px in its top bits; reorder so pixel_x sits lowest
    assign m_tdata = {{(OutBits-PixBits){1'b0}},
                      pixel[7:0], pixel[15:8], pixel[23:16], pixel[31:24],
                      pixel[33:32], pixel[35:34]};

endmodule

[rtl/etc1_front.sv]
// ----------------------------------------------------------------------------
// ETC1 front end
// Decodes base colors, tables and flip of a block; passes indices and alpha.
// ----------------------------------------------------------------------------
module etc1_front (
    input  logic [etc1_pkg::BlockBits-1:0] color_word,
    input  logic [etc1_pkg::BlockBits-1:0] alpha_word,
    output etc1_pkg::desc_t                desc
);
    import etc1_pkg::*;

    logic       diff;
    logic [4:0] r5;
    logic [4:0] g5;
    logic [4:0] b5;
    logic [4:0] r5d;
    logic [4:0] g5d;
    logic [4:0] b5d;

    assign diff = color_word[33];
    assign r5   = color_word[63:59];
    assign g5   = color_word[55:51];
    assign b5   = color_word[47:43];
    assign r5d  = r5 + {{2{color_word[58]}}, color_word[58:56]};
    assign g5d  = g5 + {{2{color_word[50]}}, color_word[50:48]};
    assign b5d  = b5 + {{2{color_word[42]}}, color_word[42:40]};

    always_comb
    begin
        if (diff)
        begin
            desc.base0 = {widen5(b5), widen5(g5), widen5(r5)};
            desc.base1 = {widen5(b5d), widen5(g5d), widen5(r5d)};
        end
        else
        begin
            desc.base0 = {widen4(color_word[47:44]), widen4(color_word[55:52]),
                          widen4(color_word[63:60])};
            desc.base1 = {widen4(color_word[43:40]), widen4(color_word[51:48]),
                          widen4(color_word[59:56])};
        end
        desc.tab0  = color_word[39:37];
        desc.tab1  = color_word[36:34];
        desc.flip  = color_word[32];
        desc.idx   = color_word[31:0];
        desc.alpha = alpha_word;
    end

endmodule

[rtl/etc1_queue.sv]
// ----------------------------------------------------------------------------
// ETC1 block queue
// Short queue of decoded blocks between front end and pixel engine.
// ----------------------------------------------------------------------------
module etc1_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  etc1_pkg::desc_t wr_desc,
    output logic            rd_valid,
    input  logic            rd_pop,
    output etc1_pkg::desc_t rd_desc
);
    import etc1_pkg::*;

    localparam int PtrBits = $clog2(QueueDepth);

    desc_t                mem [QueueDepth];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   wr_ptr_next;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_next;
    logic [PtrBits:0]     count_reg;
    logic [PtrBits:0]     count_next;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != (PtrBits+1)'(QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_desc  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/etc1_back.sv]
// ----------------------------------------------------------------------------
// ETC1 pixel engine
// Walks a block's sixteen pixels, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module etc1_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_data,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  etc1_pkg::desc_t             q_desc,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [etc1_pkg::PixBits-1:0] m_pixel,
    output logic                        m_tlast
);
    import etc1_pkg::*;

    logic               alpha_mode_reg;
    logic [CntBits-1:0] cnt_reg;
    logic [CntBits-1:0] cnt_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    pixel_t             pix_reg;
    pixel_t             pix_next;
    logic               last_reg;
    logic               load;
    logic [1:0]         px;
    logic [1:0]         py;
    logic [3:0]         p;
    logic               half;
    logic               neg;
    logic [7:0]         mag;
    logic [3:0]         nib;
    chan_t [2:0]        base;
    chan_t [2:0]        chan;
    logic [9:0]         sum [3];

    assign load  = q_valid && (!m_valid_reg || m_tready);
    assign q_pop = load && (cnt_reg == LastPix);

    assign py   = cnt_reg[3:2];
    assign px   = cnt_reg[1:0];
    assign p    = {px, py};
    assign half = q_desc.flip ? py[1] : px[1];
    assign neg  = q_desc.idx[{1'b1, p}];
    assign mag  = mod_mag(half ? q_desc.tab1 : q_desc.tab0, q_desc.idx[{1'b0, p}]);
    assign base = half ? q_desc.base1 : q_desc.base0;
    assign nib  = q_desc.alpha[{p, 2'b00} +: 4];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = neg ? ({2'b00, base[c]} - {2'b00, mag})
                         : ({2'b00, base[c]} + {2'b00, mag});
            if (sum[c][9])
            begin
                chan[c] = 8'd0;
            end
            else if (sum[c][8])
            begin
                chan[c] = 8'd255;
            end
            else
            begin
                chan[c] = sum[c][7:0];
            end
        end
        pix_next.px = px;
        pix_next.py = py;
        pix_next.r  = chan[0];
        pix_next.g  = chan[1];
        pix_next.b  = chan[2];
        pix_next.a  = alpha_mode_reg ? {nib, nib} : 8'd255;

        cnt_next     = load ? cnt_reg + 1'b1 : cnt_reg;
        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_tready);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= pix_next;
            last_reg <= (cnt_reg == LastPix);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                alpha_mode_reg <= cfg_data;
            end
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_pixel  = pix_reg;
    assign m_tlast  = last_reg;

endmodule

[tb/etc1_block_decoder_checker.sv]
// ----------------------------------------------------------------------------
// ETC1 block decoder checker
// Watches the input, output and configuration channels of the block decoder.
// Every accepted block is decoded here into its sixteen expected pixels.
// Every accepted pixel is compared with the oldest pixel still expected.
// ----------------------------------------------------------------------------
module etc1_block_decoder_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [etc1_pkg::InBits-1:0]   s_tdata,   // color_word, alpha_word
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [etc1_pkg::OutBits-1:0]  m_tdata,   // pixel_x, pixel_y, red,
                                                     // green, blue, alpha, pad
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_data,
    output int                            mismatch_count,
    output int                            pixels_pending
);

    typedef struct packed {
        logic [1:0] px;
        logic [1:0] py;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_rec_t;

    // modifier magnitudes per table: small, large
    int modifier_mag [8][2] = '{
        '{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
        '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}
    };

    pixel_rec_t pending_pixels [$];
    logic       alpha_mode;
    int         errors;

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'hFF;
        return v[7:0];
    endfunction

    function automatic void predict_block(input logic [63:0] cw, input logic [63:0] aw);
        int         base [2][3];
        logic [2:0] tab [2];
        logic [4:0] c5;
        logic [4:0] sum5;
        logic [2:0] d3;
        logic [3:0] n0;
        logic [3:0] n1;
        int         pos;
        int         p;
        int         half;
        int         mag;
        pixel_rec_t rec;

        tab[0] = cw[39:37];
        tab[1] = cw[36:34];
        for (int ch = 0; ch < 3; ch++)
        begin
            pos = 63 - 8 * ch;
            if (cw[33])
            begin
                c5   = cw[pos -: 5];
                d3   = cw[pos - 5 -: 3];
                sum5 = c5 + {{2{d3[2]}}, d3};
                base[0][ch] = {c5, c5[4:2]};
                base[1][ch] = {sum5, sum5[4:2]};
            end
            else
            begin
                n0 = cw[pos -: 4];
                n1 = cw[pos - 4 -: 4];
                base[0][ch] = {n0, n0};
                base[1][ch] = {n1, n1};
            end
        end

        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                p    = x * 4 + y;
                half = cw[32] ? (y >= 2) : (x >= 2);
                mag  = modifier_mag[tab[half]][cw[p]];
                if (cw[p + 16])
                    mag = -mag;
                rec.px    = 2'(x);
                rec.py    = 2'(y);
                rec.red   = clamp_byte(base[half][0] + mag);
                rec.green = clamp_byte(base[half][1] + mag);
                rec.blue  = clamp_byte(base[half][2] + mag);
                rec.alpha = alpha_mode ? {aw[4 * p +: 4], aw[4 * p +: 4]} : 8'hFF;
                rec.last  = (x == 3 && y == 3);
                pending_pixels.push_back(rec);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_rec_t got;
        pixel_rec_t want;
        if (!rst_n)
        begin
            alpha_mode = 1'b0;
            errors     = 0;
            pending_pixels.delete();
            mismatch_count <= 0;
            pixels_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                alpha_mode = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got.px    = m_tdata[1:0];
                got.py    = m_tdata[3:2];
                got.red   = m_tdata[11:4];
                got.green = m_tdata[19:12];
                got.blue  = m_tdata[27:20];
                got.alpha = m_tdata[35:28];
                got.last  = m_tlast;
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel x=%0d y=%0d rgba=%h %h %h %h last=%b",
                             $time, got.px, got.py, got.red, got.green, got.blue,
                             got.alpha, got.last);
                    errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected x=%0d y=%0d rgba=%h %h %h %h last=%b",
                                 $time, want.px, want.py, want.red, want.green,
                                 want.blue, want.alpha, want.last);
                        $display("%0t:   actual x=%0d y=%0d rgba=%h %h %h %h last=%b",
                                 $time, got.px, got.py, got.red, got.green,
                                 got.blue, got.alpha, got.last);
                        errors++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                predict_block(s_tdata[63:0], s_tdata[127:64]);

            mismatch_count <= errors;
            pixels_pending <= pending_pixels.size();
        end
    end

endmodule

[tb/etc1_block_decoder_tb.sv]
// ----------------------------------------------------------------------------
// ETC1 block decoder testbench
// Drives directed and random ETC1 / ETC1A4 blocks through the decoder under
// several sender and receiver idle patterns and both alpha modes, with a
// long output hold-off; the checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module etc1_block_decoder_tb;

    localparam int QuietLimit    = 5000;
    localparam int HoldoffCycles = 200;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [etc1_pkg::InBits-1:0]   s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [etc1_pkg::OutBits-1:0]  m_tdata;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_data  = 1'b0;

    int mismatch_count;
    int pixels_pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int holdoff_req  = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    etc1_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    etc1_block_decoder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    // hold off the output during a requested stretch, else stall at random
    always @(posedge clk)
    begin
        if (holdoff_req != holdoff_seen)
        begin
            m_tready     <= 1'b0;
            holdoff_seen <= holdoff_req;
            holdoff_left <= HoldoffCycles - 1;
        end
        else if (holdoff_left > 0)
        begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QuietLimit)
            begin
                $display("FAIL etc1_block_decoder");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] make_color(input logic diff, input logic flip,
                                                input logic [2:0] tab0, input logic [2:0] tab1,
                                                input logic [23:0] colors,
                                                input logic [31:0] idx);
        return {colors, tab0, tab1, diff, flip, idx};
    endfunction

    function automatic logic [127:0] random_block();
        logic [63:0] cw;
        logic [63:0] aw;
        cw = {$urandom, $urandom};
        aw = {$urandom, $urandom};
        case ($urandom_range(7))
            0: cw[63:40] = '1;
            1: cw[63:40] = '0;
            default: ;
        endcase
        return {aw, cw};
    endfunction

    task automatic send_block(input logic [127:0] item);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pixels_pending != 0);
    endtask

    task automatic write_alpha_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opaque mode from reset
        send_block({64'h0, 64'h0});
        send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        send_block({64'h0, make_color(1'b0, 1'b0, 3'd0, 3'd7, 24'hF0F0F0, 32'h0000_FFFF)});
        send_block({64'h0, make_color(1'b0, 1'b1, 3'd7, 3'd3, 24'h0F0F0F, 32'hFFFF_FFFF)});
        send_block({64'h0, make_color(1'b1, 1'b0, 3'd1, 3'd2, 24'hFBFBFB, 32'hFFFF_0000)});
        send_block({64'h0, make_color(1'b1, 1'b1, 3'd4, 3'd5, 24'h040404, 32'h5A5A_C3C3)});
        send_block({64'h0, make_color(1'b1, 1'b0, 3'd6, 3'd6, 24'h878787, $urandom)});
        for (int t = 0; t < 8; t++)
            send_block({64'h0, make_color(1'($urandom_range(1)), 1'($urandom_range(1)),
                                          3'(t), 3'(7 - t), 24'($urandom), $urandom)});

        wait_drained();
        write_alpha_mode(1'b1);
        send_block({64'h0, 32'($urandom), 32'($urandom)});
        send_block({64'hFFFF_FFFF_FFFF_FFFF, 32'($urandom), 32'($urandom)});
        send_block({64'hFEDC_BA98_7654_3210, 32'($urandom), 32'($urandom)});
        send_block(random_block());

        for (phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            write_alpha_mode(phase[0]);
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            repeat (85) send_block(random_block());
        end

        // fill the queue against a held output, drain, then send more blocks
        wait_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 20;
        holdoff_req  = holdoff_req + 1;
        repeat (10) send_block(random_block());
        wait_drained();
        repeat (10) send_block(random_block());

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("PASS etc1_block_decoder");
        else
            $display("FAIL etc1_block_decoder");
        $finish;
    end

endmodule

[sim.f]
rtl/etc1_pkg.sv
rtl/etc1_front.sv
rtl/etc1_queue.sv
rtl/etc1_back.sv
rtl/etc1_block_decoder.sv
tb/etc1_block_decoder_checker.sv
tb/etc1_block_decoder_tb.sv
